>>> rtl/afk7_pkg.sv
`default_nettype none
package afk7_pkg;

	localparam int ANGLE_FRAC_BITS = 13;
	localparam int TRIG_FRAC_BITS  = 14;
	localparam int POS_FRAC_BITS   = 16;

	localparam int LANES   = 7;
	localparam int ANGLE_W = 16;
	localparam int ROT_W   = 16;
	localparam int POS_W   = 18;
	localparam int ROTS    = 9;
	localparam int IN_W    = LANES * ANGLE_W;
	localparam int OUT_BITS = ROTS * ROT_W + 3 * POS_W;
	localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8;
	localparam int POS_LSB = ROTS * ROT_W;

	// working width of the matrix terms: sums of products stay below 32.0
	localparam int MW = TRIG_FRAC_BITS + 6;
	localparam int PW = 2 * MW;
	localparam int NW = TRIG_FRAC_BITS + 16;

	typedef logic signed [MW-1:0] fix_t;
	typedef logic [30:0] q30_t;
	typedef logic signed [NW-1:0] num_t;

	localparam longint unsigned TURNS_Q32 = 64'd683565276;
	localparam longint unsigned PI_Q30    = 64'd3373259426;
	localparam q30_t ONE_Q30 = 31'h4000_0000;
	localparam logic [29:0] OCTANT = 30'h2000_0000;

	// exact quotient of a 31-bit value: (a * M) >> S, S = 31 + ceil(log2 d)
	localparam int S42 = 37;
	localparam int S56 = 37;
	localparam int S20 = 36;
	localparam int S30 = 36;
	localparam int S6  = 34;
	localparam int S12 = 35;
	localparam longint unsigned M42 = ((64'd1 << S42) + 64'd41) / 64'd42;
	localparam longint unsigned M56 = ((64'd1 << S56) + 64'd55) / 64'd56;
	localparam longint unsigned M20 = ((64'd1 << S20) + 64'd19) / 64'd20;
	localparam longint unsigned M30 = ((64'd1 << S30) + 64'd29) / 64'd30;
	localparam longint unsigned M6  = ((64'd1 << S6) + 64'd5) / 64'd6;
	localparam longint unsigned M12 = ((64'd1 << S12) + 64'd11) / 64'd12;

	localparam int RT_SH = 30 - TRIG_FRAC_BITS;
	localparam longint unsigned RT_HALF = 64'd1 << (29 - TRIG_FRAC_BITS);
	localparam fix_t TRIG_ONE = fix_t'(64'd1 << TRIG_FRAC_BITS);

	localparam int ROT_RSH = (TRIG_FRAC_BITS > 14) ? TRIG_FRAC_BITS - 14 : 0;
	localparam int ROT_LSH = (TRIG_FRAC_BITS < 14) ? 14 - TRIG_FRAC_BITS : 0;
	localparam longint unsigned ROT_HALF = (ROT_RSH > 0) ? (64'd1 << (ROT_RSH - 1)) : 64'd0;
	localparam int ROT_MAX = 16384;

	localparam longint BASE_Z = 340 * (64'sd1 << TRIG_FRAC_BITS);
	localparam int POS_UP = (POS_FRAC_BITS >= TRIG_FRAC_BITS) ? POS_FRAC_BITS - TRIG_FRAC_BITS : 0;
	localparam int POS_DN = (POS_FRAC_BITS < TRIG_FRAC_BITS) ? TRIG_FRAC_BITS - POS_FRAC_BITS : 0;
	localparam int YW = 27;
	localparam longint unsigned Y_MAX = 64'd131072000;
	localparam int K_S = YW + 10;
	localparam longint unsigned K_M = ((64'd1 << K_S) + 64'd999) / 64'd1000;
	localparam int POS_MAX = 131071;

	function automatic logic [31:0] phase_of(input logic signed [ANGLE_W-1:0] a);
		logic signed [63:0] p;
		p = 64'(a) * $signed(TURNS_Q32);
		return p[ANGLE_FRAC_BITS+31:ANGLE_FRAC_BITS];
	endfunction

	// residual of the octant in radians, Q30
	function automatic logic [29:0] resid_of(input logic [31:0] ph);
		logic [29:0] m;
		logic [63:0] t;
		m = ph[29] ? (OCTANT - 30'(ph[28:0])) : 30'(ph[28:0]);
		t = (64'(m) * PI_Q30 + 64'(ONE_Q30)) >> 31;
		return t[29:0];
	endfunction

	function automatic q30_t fm30(input q30_t a, input q30_t b);
		logic [63:0] p;
		p = 64'(a) * 64'(b) + (64'd1 << 29);
		return p[60:30];
	endfunction

	function automatic q30_t divc(input q30_t a, input longint unsigned mul, input int sh);
		logic [63:0] p;
		p = (64'(a) * mul) >> sh;
		return p[30:0];
	endfunction

	function automatic fix_t trig_round(input q30_t v);
		logic [31:0] t;
		t = (32'(v) + 32'(RT_HALF)) >> RT_SH;
		return fix_t'(t);
	endfunction

	function automatic fix_t sin_fin(input logic [2:0] k, input q30_t s, input q30_t c);
		fix_t t;
		t = trig_round((k[1] ^ k[0]) ? c : s);
		return k[2] ? -t : t;
	endfunction

	function automatic fix_t cos_fin(input logic [2:0] k, input q30_t s, input q30_t c);
		fix_t t;
		t = trig_round((k[1] ^ k[0]) ? s : c);
		return (k[2] ^ k[1]) ? -t : t;
	endfunction

	function automatic fix_t qmul(input fix_t a, input fix_t b);
		logic signed [PW-1:0] p;
		logic [PW-1:0] mag;
		fix_t r;
		p = PW'(a) * PW'(b);
		mag = p[PW-1] ? PW'(-p) : PW'(p);
		mag = (mag + (PW'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
		r = fix_t'(mag[MW-1:0]);
		return p[PW-1] ? -r : r;
	endfunction

	function automatic logic signed [ROT_W-1:0] rot_out(input fix_t v);
		logic [MW+7:0] mag;
		logic signed [MW+8:0] r;
		mag = v[MW-1] ? (MW+8)'(-v) : (MW+8)'(v);
		mag = ((mag + (MW+8)'(ROT_HALF)) >> ROT_RSH) << ROT_LSH;
		r = $signed({1'b0, mag});
		if (v[MW-1])
			r = -r;
		if (r > ROT_MAX)
			r = (MW+9)'(ROT_MAX);
		if (r < -ROT_MAX)
			r = -(MW+9)'(ROT_MAX);
		return r[ROT_W-1:0];
	endfunction

	function automatic num_t pos_num(input fix_t a, input fix_t b, input logic base);
		longint t;
		t = 400 * longint'(a) + 111 * longint'(b) + (base ? BASE_Z : 64'sd0);
		return NW'(t);
	endfunction

	// rounded magnitude ahead of the divide by 1000, clamped at saturation
	function automatic logic [YW-1:0] pos_pre(input num_t num);
		logic [NW-1:0] n;
		logic [63:0] y;
		n = num[NW-1] ? NW'(-num) : NW'(num);
		y = ((64'(n) << POS_UP) >> POS_DN) + 64'd500;
		if (y > Y_MAX)
			y = Y_MAX;
		return y[YW-1:0];
	endfunction

	function automatic logic signed [POS_W-1:0] pos_fin(input logic [YW-1:0] y, input logic neg);
		logic [63:0] q;
		logic signed [POS_W:0] r;
		q = (64'(y) * K_M) >> K_S;
		r = $signed({1'b0, q[POS_W-1:0]});
		if (neg)
			r = -r;
		if (r > POS_MAX)
			r = (POS_W+1)'(POS_MAX);
		return r[POS_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/arm_forward_kinematics_7dof.sv
// Forward kinematics of a seven-joint arm, one pose per transaction.
// Throughput: one transaction per cycle unless m_tready holds the output, through an
// 18-stage pipeline (phase multiply, Horner sine/cosine steps, the matrix product tree,
// divide).
// Reset (arst_n low) clears the stage valid bits only; data registers keep garbage.
`default_nettype none
module arm_forward_kinematics_7dof (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// joint_1_angle .. joint_7_angle, 16 bits each, from bit 0 up
	input  wire logic [afk7_pkg::IN_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// rot_r0_c0 .. rot_r2_c2 (16 bits each), pos_x, pos_y, pos_z (18 bits each),
	// from bit 0 up, two zero bits on top
	output logic [afk7_pkg::OUT_W-1:0]       m_tdata
);
	import afk7_pkg::*;

	localparam int NS = 18;

	logic [NS:1] v, en;

	always_comb begin
		en[NS] = ~v[NS] | m_tready;
		for (int k = NS - 1; k >= 1; k--)
			en[k] = ~v[k] | en[k+1];
	end

	assign s_tready = en[1];
	assign m_tvalid = v[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1])
				v[1] <= s_tvalid;
			for (int k = 2; k <= NS; k++)
				if (en[k])
					v[k] <= v[k-1];
		end
	end

	// sine / cosine lanes
	logic [31:0] ph_s1 [LANES];
	logic [29:0] x_s2 [LANES], x_s3 [LANES], x_s4 [LANES], x_s5 [LANES];
	logic [29:0] x_s6 [LANES], x_s7 [LANES], x_s8 [LANES];
	logic [29:0] x2_s3 [LANES], x2_s4 [LANES], x2_s5 [LANES], x2_s6 [LANES];
	logic [29:0] x2_s7 [LANES], x2_s8 [LANES];
	logic [2:0]  k_s2 [LANES], k_s3 [LANES], k_s4 [LANES], k_s5 [LANES];
	logic [2:0]  k_s6 [LANES], k_s7 [LANES], k_s8 [LANES], k_s9 [LANES];
	q30_t h_s4 [LANES], g_s4 [LANES], hp_s5 [LANES], gp_s5 [LANES];
	q30_t h_s6 [LANES], g_s6 [LANES], hp_s7 [LANES], gp_s7 [LANES];
	q30_t h_s8 [LANES], g_s8 [LANES], sv_s9 [LANES], gp_s9 [LANES];

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			if (en[1])
				ph_s1[i] <= phase_of($signed(s_tdata[i*ANGLE_W +: ANGLE_W]));
			if (en[2]) begin
				x_s2[i] <= resid_of(ph_s1[i]);
				k_s2[i] <= ph_s1[i][31:29];
			end
			if (en[3]) begin
				x_s3[i]  <= x_s2[i];
				k_s3[i]  <= k_s2[i];
				x2_s3[i] <= 30'(fm30(31'(x_s2[i]), 31'(x_s2[i])));
			end
			if (en[4]) begin
				x_s4[i]  <= x_s3[i];
				k_s4[i]  <= k_s3[i];
				x2_s4[i] <= x2_s3[i];
				h_s4[i]  <= ONE_Q30 - divc(31'(x2_s3[i]), M42, S42);
				g_s4[i]  <= ONE_Q30 - divc(31'(x2_s3[i]), M56, S56);
			end
			if (en[5]) begin
				x_s5[i]  <= x_s4[i];
				k_s5[i]  <= k_s4[i];
				x2_s5[i] <= x2_s4[i];
				hp_s5[i] <= fm30(31'(x2_s4[i]), h_s4[i]);
				gp_s5[i] <= fm30(31'(x2_s4[i]), g_s4[i]);
			end
			if (en[6]) begin
				x_s6[i]  <= x_s5[i];
				k_s6[i]  <= k_s5[i];
				x2_s6[i] <= x2_s5[i];
				h_s6[i]  <= ONE_Q30 - divc(hp_s5[i], M20, S20);
				g_s6[i]  <= ONE_Q30 - divc(gp_s5[i], M30, S30);
			end
			if (en[7]) begin
				x_s7[i]  <= x_s6[i];
				k_s7[i]  <= k_s6[i];
				x2_s7[i] <= x2_s6[i];
				hp_s7[i] <= fm30(31'(x2_s6[i]), h_s6[i]);
				gp_s7[i] <= fm30(31'(x2_s6[i]), g_s6[i]);
			end
			if (en[8]) begin
				x_s8[i]  <= x_s7[i];
				k_s8[i]  <= k_s7[i];
				x2_s8[i] <= x2_s7[i];
				h_s8[i]  <= ONE_Q30 - divc(hp_s7[i], M6, S6);
				g_s8[i]  <= ONE_Q30 - divc(gp_s7[i], M12, S12);
			end
			if (en[9]) begin
				k_s9[i]  <= k_s8[i];
				sv_s9[i] <= fm30(31'(x_s8[i]), h_s8[i]);
				gp_s9[i] <= fm30(31'(x2_s8[i]), g_s8[i]);
			end
		end
	end

	// joint sines and cosines, lane 0 is joint 1
	fix_t sn_s10 [LANES], cs_s10 [LANES], sn_s11 [LANES], cs_s11 [LANES];
	fix_t sn_s12 [LANES], cs_s12 [LANES], sn_s13 [LANES], cs_s13 [LANES];
	fix_t sn_s14 [LANES], cs_s14 [LANES], sn_s15 [LANES], cs_s15 [LANES];

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			if (en[10]) begin
				sn_s10[i] <= sin_fin(k_s9[i], sv_s9[i], ONE_Q30 - (gp_s9[i] >> 1));
				cs_s10[i] <= cos_fin(k_s9[i], sv_s9[i], ONE_Q30 - (gp_s9[i] >> 1));
			end
			if (en[11]) begin
				sn_s11[i] <= sn_s10[i];
				cs_s11[i] <= cs_s10[i];
			end
			if (en[12]) begin
				sn_s12[i] <= sn_s11[i];
				cs_s12[i] <= cs_s11[i];
			end
			if (en[13]) begin
				sn_s13[i] <= sn_s12[i];
				cs_s13[i] <= cs_s12[i];
			end
			if (en[14]) begin
				sn_s14[i] <= sn_s13[i];
				cs_s14[i] <= cs_s13[i];
			end
			if (en[15]) begin
				sn_s15[i] <= sn_s14[i];
				cs_s15[i] <= cs_s14[i];
			end
		end
	end

	// pairwise products of joint terms
	fix_t s1s3_s11, c1c2_s11, s1c3_s11, c1s3_s11, c1s2_s11, c1c4_s11, s1c2_s11;
	fix_t s1s2_s11, c1c3_s11, c4s1_s11, c2s4_s11, c4c3_s11, s3s2_s11, c4c2_s11;
	fix_t c3s2_s11;

	always_ff @(posedge clk) begin
		if (en[11]) begin
			s1s3_s11 <= qmul(sn_s10[0], sn_s10[2]);
			c1c2_s11 <= qmul(cs_s10[0], cs_s10[1]);
			s1c3_s11 <= qmul(sn_s10[0], cs_s10[2]);
			c1s3_s11 <= qmul(cs_s10[0], sn_s10[2]);
			c1s2_s11 <= qmul(cs_s10[0], sn_s10[1]);
			c1c4_s11 <= qmul(cs_s10[0], cs_s10[3]);
			s1c2_s11 <= qmul(sn_s10[0], cs_s10[1]);
			s1s2_s11 <= qmul(sn_s10[0], sn_s10[1]);
			c1c3_s11 <= qmul(cs_s10[0], cs_s10[2]);
			c4s1_s11 <= qmul(cs_s10[3], sn_s10[0]);
			c2s4_s11 <= qmul(cs_s10[1], sn_s10[3]);
			c4c3_s11 <= qmul(cs_s10[3], cs_s10[2]);
			s3s2_s11 <= qmul(sn_s10[2], sn_s10[1]);
			c4c2_s11 <= qmul(cs_s10[3], cs_s10[1]);
			c3s2_s11 <= qmul(cs_s10[2], sn_s10[1]);
		end
	end

	fix_t a9_s12, a19_s12, a38_s12, a43_s12, a57_s12, a66_s12;
	fix_t t_c1s2s4_s12, t_c1c4s2_s12, t_s1s2s4_s12, t_c4s1s2_s12;
	fix_t t_s3s2c5_s12, t_s3s2s5_s12, c1s2_s12, s1s2_s12;

	always_ff @(posedge clk) begin
		if (en[12]) begin
			a9_s12       <= s1s3_s11 - qmul(c1c2_s11, cs_s11[2]);
			a19_s12      <= s1c3_s11 + qmul(c1s3_s11, cs_s11[1]);
			a38_s12      <= c1s3_s11 + qmul(s1c2_s11, cs_s11[2]);
			a43_s12      <= c1c3_s11 - qmul(s1s3_s11, cs_s11[1]);
			a57_s12      <= c2s4_s11 - qmul(c4c3_s11, sn_s11[1]);
			a66_s12      <= c4c2_s11 + qmul(c3s2_s11, sn_s11[3]);
			t_c1s2s4_s12 <= qmul(c1s2_s11, sn_s11[3]);
			t_c1c4s2_s12 <= qmul(c1c4_s11, sn_s11[1]);
			t_s1s2s4_s12 <= qmul(s1s2_s11, sn_s11[3]);
			t_c4s1s2_s12 <= qmul(c4s1_s11, sn_s11[1]);
			t_s3s2c5_s12 <= qmul(s3s2_s11, cs_s11[4]);
			t_s3s2s5_s12 <= qmul(s3s2_s11, sn_s11[4]);
			c1s2_s12     <= c1s2_s11;
			s1s2_s12     <= s1s2_s11;
		end
	end

	fix_t a15_s13, a24_s13, a41_s13, a45_s13, a60_s13, a63_s13;
	fix_t a19_s13, a43_s13, a66_s13, c1s2_s13, s1s2_s13;

	always_ff @(posedge clk) begin
		if (en[13]) begin
			a15_s13  <= qmul(cs_s12[3], a9_s12) - t_c1s2s4_s12;
			a24_s13  <= qmul(a9_s12, sn_s12[3]) + t_c1c4s2_s12;
			a41_s13  <= qmul(cs_s12[3], a38_s12) + t_s1s2s4_s12;
			a45_s13  <= qmul(sn_s12[3], a38_s12) - t_c4s1s2_s12;
			a60_s13  <= qmul(sn_s12[4], a57_s12) - t_s3s2c5_s12;
			a63_s13  <= qmul(cs_s12[4], a57_s12) + t_s3s2s5_s12;
			a19_s13  <= a19_s12;
			a43_s13  <= a43_s12;
			a66_s13  <= a66_s12;
			c1s2_s13 <= c1s2_s12;
			s1s2_s13 <= s1s2_s12;
		end
	end

	fix_t a30_s14, a35_s14, a50_s14, a54_s14, d_s14, m22_s14;
	fix_t a24_s14, a45_s14, a60_s14, pax_s14, pay_s14, paz_s14;

	always_ff @(posedge clk) begin
		if (en[14]) begin
			a30_s14 <= qmul(a15_s13, cs_s13[4]) + qmul(sn_s13[4], a19_s13);
			a35_s14 <= qmul(sn_s13[4], a15_s13) - qmul(cs_s13[4], a19_s13);
			a50_s14 <= qmul(cs_s13[4], a41_s13) + qmul(sn_s13[4], a43_s13);
			a54_s14 <= qmul(sn_s13[4], a41_s13) - qmul(cs_s13[4], a43_s13);
			d_s14   <= qmul(sn_s13[5], a66_s13) - qmul(cs_s13[5], a63_s13);
			m22_s14 <= qmul(sn_s13[5], a63_s13) + qmul(cs_s13[5], a66_s13);
			a24_s14 <= a24_s13;
			a45_s14 <= a45_s13;
			a60_s14 <= a60_s13;
			pax_s14 <= c1s2_s13 + a24_s13;
			pay_s14 <= s1s2_s13 - a45_s13;
			paz_s14 <= cs_s13[1] + a66_s13;
		end
	end

	fix_t a32_s15, m02_s15, a52_s15, m12_s15, r6_s15, r7_s15;
	fix_t a35_s15, a54_s15, m22_s15, pax_s15, pay_s15, paz_s15;

	always_ff @(posedge clk) begin
		if (en[15]) begin
			a32_s15 <= qmul(sn_s14[5], a24_s14) + qmul(cs_s14[5], a30_s14);
			m02_s15 <= qmul(a24_s14, cs_s14[5]) - qmul(sn_s14[5], a30_s14);
			a52_s15 <= qmul(sn_s14[5], a45_s14) + qmul(cs_s14[5], a50_s14);
			m12_s15 <= qmul(sn_s14[5], a50_s14) - qmul(cs_s14[5], a45_s14);
			r6_s15  <= -qmul(sn_s14[6], a60_s14) - qmul(cs_s14[6], d_s14);
			r7_s15  <= -qmul(cs_s14[6], a60_s14) + qmul(sn_s14[6], d_s14);
			a35_s15 <= a35_s14;
			a54_s15 <= a54_s14;
			m22_s15 <= m22_s14;
			pax_s15 <= pax_s14;
			pay_s15 <= pay_s14;
			paz_s15 <= paz_s14;
		end
	end

	fix_t rot_s16 [ROTS];
	num_t num_s16 [3];

	always_ff @(posedge clk) begin
		if (en[16]) begin
			rot_s16[0] <= qmul(sn_s15[6], a35_s15) - qmul(a32_s15, cs_s15[6]);
			rot_s16[1] <= qmul(sn_s15[6], a32_s15) + qmul(cs_s15[6], a35_s15);
			rot_s16[2] <= m02_s15;
			rot_s16[3] <= -qmul(sn_s15[6], a54_s15) + qmul(cs_s15[6], a52_s15);
			rot_s16[4] <= -qmul(sn_s15[6], a52_s15) - qmul(cs_s15[6], a54_s15);
			rot_s16[5] <= m12_s15;
			rot_s16[6] <= r6_s15;
			rot_s16[7] <= r7_s15;
			rot_s16[8] <= m22_s15;
			num_s16[0] <= pos_num(pax_s15, m02_s15, 1'b0);
			num_s16[1] <= pos_num(pay_s15, m12_s15, 1'b0);
			num_s16[2] <= pos_num(paz_s15, m22_s15, 1'b1);
		end
	end

	logic signed [ROT_W-1:0] rot_s17 [ROTS], rot_s18 [ROTS];
	logic [YW-1:0]           y_s17 [3];
	logic                    neg_s17 [3];
	logic signed [POS_W-1:0] pos_s18 [3];

	always_ff @(posedge clk) begin
		for (int r = 0; r < ROTS; r++) begin
			if (en[17])
				rot_s17[r] <= rot_out(rot_s16[r]);
			if (en[18])
				rot_s18[r] <= rot_s17[r];
		end
		for (int p = 0; p < 3; p++) begin
			if (en[17]) begin
				y_s17[p]   <= pos_pre(num_s16[p]);
				neg_s17[p] <= num_s16[p][NW-1];
			end
			if (en[18])
				pos_s18[p] <= pos_fin(y_s17[p], neg_s17[p]);
		end
	end

	always_comb begin
		m_tdata = '0;
		for (int r = 0; r < ROTS; r++)
			m_tdata[r*ROT_W +: ROT_W] = rot_s18[r];
		for (int p = 0; p < 3; p++)
			m_tdata[POS_LSB + p*POS_W +: POS_W] = pos_s18[p];
	end

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output stage");

	a_sin1_range: assert property (@(posedge clk) disable iff (!arst_n)
		v[10] |-> (sn_s10[0] <= TRIG_ONE && sn_s10[0] >= -TRIG_ONE))
		else $error("joint 1 sine out of range");

	a_cos7_range: assert property (@(posedge clk) disable iff (!arst_n)
		v[10] |-> (cs_s10[6] <= TRIG_ONE && cs_s10[6] >= -TRIG_ONE))
		else $error("joint 7 cosine out of range");

	a_out_move: assert property (@(posedge clk) disable iff (!arst_n)
		(v[NS-1] && m_tvalid && m_tready) |=> m_tvalid)
		else $error("pipeline lost a transaction at the output stage");
`endif

endmodule
`default_nettype wire
